// File: rtl/core/sfps_pkg.sv
// Shared types and constants of the shape fill pixel shader.
package sfps_pkg;

  typedef enum logic [1:0] {
    SHAPE_RECT = 2'd0,
    SHAPE_CIRC = 2'd1,
    SHAPE_GRAD = 2'd2,
    SHAPE_NONE = 2'd3
  } shape_e;

  typedef enum logic [2:0] {
    REG_SHAPE_MODE = 3'd0,
    REG_ORIGIN_X   = 3'd1,
    REG_ORIGIN_Y   = 3'd2,
    REG_EXTENT_W   = 3'd3,
    REG_EXTENT_H   = 3'd4,
    REG_COLOR_A    = 3'd5,
    REG_COLOR_B    = 3'd6,
    REG_ALPHA      = 3'd7
  } reg_e;

  localparam logic [7:0] AlphaOpaque = 8'hFF;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [23:0] dest_color;
  } pix_in_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] pixel_address;
    logic [23:0] new_color;
  } pix_out_t;

  typedef struct packed {
    logic [1:0]         shape_mode;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
    logic [11:0]        extent_w;
    logic [11:0]        extent_h;
    logic [23:0]        color_a;
    logic [23:0]        color_b;
    logic [7:0]         alpha;
  } cfg_t;

  // Classified item handed from the front part to the back part.
  typedef struct packed {
    logic               hit;       // covered, on screen, and alpha nonzero or gradient
    logic               grad;
    logic               blend;     // alpha below 255
    logic signed [13:0] dy;
    logic [23:0]        addr;
    logic [23:0]        dst;
  } work_t;

  // x / 255 for x < 65280: ((x + 1) + ((x + 1) >> 8)) >> 8.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    logic [17:0] u;
    begin
      t = {1'b0, x} + 17'd1;
      u = {1'b0, t} + {9'd0, t[16:8]};
      div255 = u[15:8];
    end
  endfunction

endpackage

// File: rtl/core/sfps_front.sv
// Front part: coverage test, screen clip and address for one pixel.
module sfps_front
  import sfps_pkg::*;
#(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 768
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  pix_in_t in_i,
  input  cfg_t    cfg_i,
  output logic    out_valid_o,
  output work_t   out_o
);

  // Stage 1 registers the differences (the squares' operands), the on-screen flag, address, dest color and mode.
  logic               s1_valid_q;
  logic signed [13:0] dx_q, dy_q;
  logic               on_screen_q;
  logic [23:0]        addr_q, dst_q;
  logic [1:0]         mode_q;

  logic signed [13:0] dx_d, dy_d;
  logic [35:0]        addr_full;

  assign dx_d = $signed({2'b00, in_i.pixel_x}) - 14'(cfg_i.origin_x);
  assign dy_d = $signed({2'b00, in_i.pixel_y}) - 14'(cfg_i.origin_y);
  assign addr_full = 36'(in_i.pixel_y) * 36'(SCREEN_W) + 36'(in_i.pixel_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    on_screen_q <= (32'(in_i.pixel_x) < SCREEN_W) && (32'(in_i.pixel_y) < SCREEN_H);
    addr_q      <= addr_full[23:0];
    dst_q       <= in_i.dest_color;
    mode_q      <= cfg_i.shape_mode;
  end

  // Stage 2 squares and classifies.
  logic [27:0] dx2, dy2, r2;
  logic [28:0] dsum;
  logic        rect_cov, circ_cov, cov;

  assign dx2  = 28'(dx_q * dx_q);
  assign dy2  = 28'(dy_q * dy_q);
  assign r2   = 28'({12'd0, cfg_i.extent_w} * {12'd0, cfg_i.extent_w});
  assign dsum = {1'b0, dx2} + {1'b0, dy2};
  assign rect_cov = !dx_q[13] && !dy_q[13]
                 && (dx_q < $signed({2'b00, cfg_i.extent_w}))
                 && (dy_q < $signed({2'b00, cfg_i.extent_h}));
  assign circ_cov = dsum <= {1'b0, r2};

  always_comb begin
    unique case (shape_e'(mode_q))
      SHAPE_RECT, SHAPE_GRAD: cov = rect_cov;
      SHAPE_CIRC:             cov = circ_cov;
      default:                cov = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o.grad  <= (mode_q == SHAPE_GRAD);
    out_o.hit   <= cov && on_screen_q
                && ((mode_q == SHAPE_GRAD) || (cfg_i.alpha != 8'd0));
    out_o.blend <= (cfg_i.alpha != AlphaOpaque);
    out_o.dy    <= dy_q;
    out_o.addr  <= addr_q;
    out_o.dst   <= dst_q;
  end

endmodule

// File: rtl/core/sfps_queue.sv
// Short queue between the front and back parts.
module sfps_queue
  import sfps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  input  logic  pop_i,
  output logic  valid_o,
  output work_t data_o
);

  work_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i && valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i && valid_o);
    end
  end

endmodule

// File: rtl/core/sfps_back.sv
// Back part: gradient and alpha blend color, with a registered result.
module sfps_back
  import sfps_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  work_t    in_i,
  input  cfg_t     cfg_i,
  output logic     out_valid_o,
  output pix_out_t out_o
);

  // Stage 1: per channel products.
  logic                s1_valid_q;
  work_t               w1_q;
  logic signed [22:0]  gprod_q [3];
  logic [15:0]         bsum_q  [3];

  logic signed [8:0]   diff   [3];
  logic [7:0]          s_ch   [3];
  logic [7:0]          d_ch   [3];
  logic [7:0]          inv_a;

  assign inv_a = AlphaOpaque - cfg_i.alpha;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_ch[k] = cfg_i.color_a[8*k +: 8];
      d_ch[k] = in_i.dst[8*k +: 8];
      diff[k] = $signed({1'b0, cfg_i.color_b[8*k +: 8]}) - $signed({1'b0, s_ch[k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    w1_q <= in_i;
    for (int k = 0; k < 3; k++) begin
      gprod_q[k] <= 23'(in_i.dy * diff[k]);
      bsum_q[k]  <= 16'(s_ch[k] * cfg_i.alpha) + 16'(d_ch[k] * inv_a);
    end
  end

  // Stage 2: gradient quotient, one restoring divider per channel, pipelined
  // over 12 quotient bits; the blend path travels alongside.
  localparam int unsigned QB = 12;

  logic              gv_q   [QB+1];
  work_t             gw_q   [QB+1];
  logic              gneg_q [3][QB+1];
  logic [22:0]       grem_q [3][QB+1];
  logic [11:0]       gquo_q [3][QB+1];
  logic [15:0]       gbs_q  [3][QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QB; i++) gv_q[i] <= 1'b0;
    end else begin
      gv_q[0] <= s1_valid_q;
      for (int i = 1; i <= QB; i++) gv_q[i] <= gv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    gw_q[0] <= w1_q;
    for (int k = 0; k < 3; k++) begin
      gneg_q[k][0] <= gprod_q[k][22];
      grem_q[k][0] <= gprod_q[k][22] ? 23'(-gprod_q[k]) : 23'(gprod_q[k]);
      gquo_q[k][0] <= 12'd0;
      gbs_q[k][0]  <= bsum_q[k];
    end
    for (int i = 1; i <= QB; i++) begin
      gw_q[i] <= gw_q[i-1];
      for (int k = 0; k < 3; k++) begin
        logic [23:0] trial;
        trial = {1'b0, grem_q[k][i-1]} - ({12'd0, cfg_i.extent_h} << (QB - i));
        gneg_q[k][i] <= gneg_q[k][i-1];
        gbs_q[k][i]  <= gbs_q[k][i-1];
        if (!trial[23]) begin
          grem_q[k][i] <= trial[22:0];
          gquo_q[k][i] <= gquo_q[k][i-1] | (12'd1 << (QB - i));
        end else begin
          grem_q[k][i] <= grem_q[k][i-1];
          gquo_q[k][i] <= gquo_q[k][i-1];
        end
      end
    end
  end

  // Output register.
  work_t fin;
  logic [23:0] color;
  assign fin = gw_q[QB];

  always_comb begin
    color = fin.dst;
    for (int k = 0; k < 3; k++) begin
      logic [7:0] q8;
      q8 = gquo_q[k][QB][7:0];
      if (fin.grad) begin
        color[8*k +: 8] = cfg_i.color_a[8*k +: 8] + (gneg_q[k][QB] ? 8'(-q8) : q8);
      end else if (fin.blend) begin
        color[8*k +: 8] = div255(gbs_q[k][QB]);
      end else begin
        color[8*k +: 8] = cfg_i.color_a[8*k +: 8];
      end
    end
    if (!fin.hit) color = fin.dst;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= gv_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    out_o.write_enable  <= fin.hit;
    out_o.pixel_address <= fin.addr;
    out_o.new_color     <= color;
  end

endmodule

// File: rtl/core/shape_fill_pixel_shader.sv
// Top level of the shape fill pixel shader: config registers, front, queue, back.
//
//   Channel   Handshake                  Payload
//   command   start / busy               pix_i   (pixel_x, pixel_y, dest_color)
//   result    done_o strobe              pix_o   (write_enable, pixel_address, new_color)
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One pixel is accepted every clock; busy stays low, since the back part
// never stalls and the receiver takes every result beat as it comes.
// A pixel passes 18 registers: two front stages, one queue stage, a product
// stage, a sign stage and the 12-step gradient divider in the back part, then
// the output register. done_o rises together with the result beat on pix_o.
// Reset clears all valid flags and sets the config registers to their reset values
// (alpha opaque, everything else zero). No clearing pass is needed.
module shape_fill_pixel_shader
  import sfps_pkg::*;
#(
  parameter int unsigned SCREEN_W = 1024,
  parameter int unsigned SCREEN_H = 768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  pix_in_t     pix_i,
  output logic        done_o,
  output pix_out_t    pix_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  // The back part runs at full rate, so the command side is never held off.
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{alpha: AlphaOpaque, default: '0};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_e'(cfg_index_i))
        REG_SHAPE_MODE: cfg_q.shape_mode <= cfg_data_i[1:0];
        REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i[12:0];
        REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_data_i[12:0];
        REG_EXTENT_W:   cfg_q.extent_w   <= cfg_data_i[11:0];
        REG_EXTENT_H:   cfg_q.extent_h   <= cfg_data_i[11:0];
        REG_COLOR_A:    cfg_q.color_a    <= cfg_data_i[23:0];
        REG_COLOR_B:    cfg_q.color_b    <= cfg_data_i[23:0];
        REG_ALPHA:      cfg_q.alpha      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic  accept;
  logic  f_valid, q_valid;
  work_t f_work, q_work;

  assign accept = start && !busy;

  sfps_front #(.SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (accept),
    .in_i       (pix_i),
    .cfg_i      (cfg_q),
    .out_valid_o(f_valid),
    .out_o      (f_work)
  );

  // The back part always pops, so the queue holds at most one beat.
  sfps_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (f_valid),
    .data_i (f_work),
    .pop_i  (1'b1),
    .valid_o(q_valid),
    .data_o (q_work)
  );

  sfps_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (q_valid),
    .in_i       (q_work),
    .cfg_i      (cfg_q),
    .out_valid_o(done_o),
    .out_o      (pix_o)
  );

  // Every accepted pixel produces its result beat on done_o.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##18 done_o) else $error("result beat missing");
  // The queue never holds two beats, since the back part pops every cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_queue.cnt_q != 2'd2) else $error("queue overfilled");
  // Every accepted pixel reaches the back part through the two front stages and the queue stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ##2 q_valid) else $error("front lost a beat");

endmodule
